[rtl/core/wwsc_pkg.sv]
package wwsc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 15;
  localparam int RMS_W      = 16;
  localparam int CLIP_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int PHASE_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_SELECT   = 2'd0,
    CFG_CLIP_THRESHOLD = 2'd1,
    CFG_TOL_LOW        = 2'd2,
    CFG_TOL_HIGH       = 2'd3
  } cfg_reg_t;

  localparam logic [PHASE_W-1:0] PHASE_A = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_B = 2'd1;

  localparam logic [PHASE_W-1:0] PHASE_SEL_RST = PHASE_A;
  localparam logic [THR_W-1:0]   CLIP_THR_RST  = 15'd20794;
  localparam logic [THR_W-1:0]   TOL_LOW_RST   = 15'd13248;
  localparam logic [THR_W-1:0]   TOL_HIGH_RST  = 15'd16192;

  typedef struct packed {
    logic load;
    logic square;
    logic accum;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic        [RMS_W-1:0]    rms;
    logic signed [SAMPLE_W-1:0] dc;
  } solv_res_t;

endpackage

[rtl/core/wwsc_in_if.sv]
interface wwsc_in_if import wwsc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] phase_a;
  logic signed [SAMPLE_W-1:0] phase_b;
  logic signed [SAMPLE_W-1:0] phase_c;
  logic                       last_sample;

  modport source (output valid, phase_a, phase_b, phase_c, last_sample, input ready);
  modport sink   (input valid, phase_a, phase_b, phase_c, last_sample, output ready);
endinterface

[rtl/core/wwsc_out_if.sv]
interface wwsc_out_if import wwsc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [RMS_W-1:0]    rms_value;
  logic        [SAMPLE_W-1:0] peak_span;
  logic signed [SAMPLE_W-1:0] dc_offset;
  logic        [CLIP_W-1:0]   clip_count;
  logic                       in_tolerance;

  modport source (output valid, rms_value, peak_span, dc_offset, clip_count, in_tolerance,
                  input ready);
  modport sink   (input valid, rms_value, peak_span, dc_offset, clip_count, in_tolerance,
                  output ready);
endinterface

[rtl/core/wwsc_acc.sv]
module wwsc_acc import wwsc_pkg::*; #(
  parameter int MAX_SAMPLES = 1024,
  parameter int CNT_W       = 11,
  parameter int SQ_W        = 42,
  parameter int SUM_W       = 27
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  acc_ctrl_t                  ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  input  logic        [THR_W-1:0]    clip_thr,
  output logic                       win_end,
  output logic        [CNT_W-1:0]    count,
  output logic        [SQ_W-1:0]     sq_sum,
  output logic signed [SUM_W-1:0]    plain_sum,
  output logic signed [SAMPLE_W-1:0] run_max,
  output logic signed [SAMPLE_W-1:0] run_min,
  output logic        [CLIP_W-1:0]   clip_cnt
);

  logic signed [SAMPLE_W-1:0]   smp_r;
  logic                         last_r;
  logic        [2*SAMPLE_W-1:0] sqr_r;
  logic                         clip_hit_r;
  logic        [CNT_W-1:0]      cnt_r;
  logic        [SQ_W-1:0]       sq_sum_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [SAMPLE_W-1:0]   max_r;
  logic signed [SAMPLE_W-1:0]   min_r;
  logic        [CLIP_W-1:0]     clip_r;

  logic [SAMPLE_W-1:0] mag;
  logic [CNT_W-1:0]    cnt_inc;

  // -32768 wraps to 0x8000, which reads correctly as an unsigned magnitude
  assign mag     = smp_r[SAMPLE_W-1] ? $unsigned(-smp_r) : $unsigned(smp_r);
  assign cnt_inc = cnt_r + 1'b1;
  assign win_end = last_r || (cnt_inc == CNT_W'(MAX_SAMPLES));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      smp_r  <= sample;
      last_r <= last;
    end
    if (ctrl.square) begin
      sqr_r      <= mag * mag;
      clip_hit_r <= (mag >= {1'b0, clip_thr});
    end
    if (ctrl.accum) begin
      // first sample of a window seeds the extremes
      if (cnt_r == '0 || smp_r > max_r) max_r <= smp_r;
      if (cnt_r == '0 || smp_r < min_r) min_r <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      cnt_r    <= '0;
      sq_sum_r <= '0;
      sum_r    <= '0;
      clip_r   <= '0;
    end else if (ctrl.accum) begin
      cnt_r    <= cnt_inc;
      sq_sum_r <= sq_sum_r + SQ_W'(sqr_r);
      sum_r    <= sum_r + SUM_W'(smp_r);
      clip_r   <= clip_r + CLIP_W'(clip_hit_r);
    end
  end

  assign count     = cnt_r;
  assign sq_sum    = sq_sum_r;
  assign plain_sum = sum_r;
  assign run_max   = max_r;
  assign run_min   = min_r;
  assign clip_cnt  = clip_r;

endmodule

[rtl/core/wwsc_solver.sv]
module wwsc_solver import wwsc_pkg::*; #(
  parameter int CNT_W = 11,
  parameter int SQ_W  = 42,
  parameter int SUM_W = 27
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SQ_W-1:0]         sq_sum,
  input  logic signed [SUM_W-1:0] plain_sum,
  input  logic [CNT_W-1:0]        count,
  output logic                    done,
  output solv_res_t               res
);

  localparam int WW     = (SQ_W > SUM_W) ? SQ_W : SUM_W;
  localparam int RT_W   = RMS_W;
  localparam int RAD_W  = 2 * RT_W;
  localparam int UW     = (CNT_W + 1 > RT_W + 3) ? CNT_W + 1 : RT_W + 3;
  localparam int STEP_W = $clog2(WW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_SQ,
    S_SQRT,
    S_DIV_DC
  } state_t;

  state_t              state_r;
  logic [WW-1:0]       work_r;
  logic [UW-1:0]       rem_r;
  logic [RT_W-1:0]     root_r;
  logic [RAD_W-1:0]    rad_r;
  logic [STEP_W-1:0]   step_r;
  logic                neg_r;
  logic [RT_W-1:0]     rms_r;
  logic signed [SAMPLE_W-1:0] dc_r;
  logic                done_r;

  logic             sqrt_mode;
  logic [UW-1:0]    op_a;
  logic [UW-1:0]    op_b;
  logic [UW:0]      diff;
  logic             ge;
  logic [UW-1:0]    rem_step;
  logic [WW-1:0]    quot_nxt;
  logic [RT_W-1:0]  root_nxt;
  logic [SUM_W-1:0] sum_mag;
  logic [RT_W-1:0]  dc_mag;

  // shared compare-subtract: restoring division step or one root digit
  assign sqrt_mode = (state_r == S_SQRT);
  assign op_a      = sqrt_mode ? {rem_r[UW-3:0], rad_r[RAD_W-1 -: 2]}
                               : {rem_r[UW-2:0], work_r[WW-1]};
  assign op_b      = sqrt_mode ? UW'({root_r, 2'b01}) : UW'(count);
  assign diff      = {1'b0, op_a} - {1'b0, op_b};
  assign ge        = ~diff[UW];
  assign rem_step  = ge ? diff[UW-1:0] : op_a;
  assign quot_nxt  = {work_r[WW-2:0], ge};
  assign root_nxt  = {root_r[RT_W-2:0], ge};
  assign sum_mag   = plain_sum[SUM_W-1] ? $unsigned(-plain_sum) : $unsigned(plain_sum);
  assign dc_mag    = quot_nxt[RT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            work_r  <= WW'(sq_sum);
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= S_DIV_SQ;
          end
        end
        S_DIV_SQ: begin
          work_r <= quot_nxt;
          rem_r  <= rem_step;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(WW - 1)) begin
            // mean square never exceeds full scale squared
            rad_r   <= quot_nxt[RAD_W-1:0];
            rem_r   <= '0;
            root_r  <= '0;
            step_r  <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad_r  <= rad_r << 2;
          rem_r  <= rem_step;
          root_r <= root_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(RT_W - 1)) begin
            rms_r   <= root_nxt;
            work_r  <= WW'(sum_mag);
            neg_r   <= plain_sum[SUM_W-1];
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= S_DIV_DC;
          end
        end
        S_DIV_DC: begin
          work_r <= quot_nxt;
          rem_r  <= rem_step;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(WW - 1)) begin
            // truncate toward zero: divide the magnitude, restore the sign
            dc_r    <= neg_r ? $signed(-dc_mag) : $signed(dc_mag);
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign res.rms = rms_r;
  assign res.dc  = dc_r;

endmodule

[rtl/core/waveform_window_statistics_core.sv]
// Window statistics meter: RMS, peak-to-peak, DC offset and clip count of one phase.
// A sample that does not end its window passes through capture, square and accumulate;
// a window-ending sample then also runs the shared compare-subtract unit through two
// W-step divisions and a 16-step root, W = 31 + clog2(MAX_SAMPLES+1); no new sample is taken meanwhile.
// The result sits in an output register; the next window proceeds while it waits.
// Synchronous active-low reset clears the accumulators and loads register defaults.
module waveform_window_statistics_core import wwsc_pkg::*; #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wwsc_in_if.sink               in_stream,
  wwsc_out_if.source            out_stream
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W  = 2 * SAMPLE_W - 1 + CNT_W;
  localparam int SUM_W = SAMPLE_W + CNT_W;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SQUARE,
    T_ACCUM,
    T_SOLVE,
    T_EMIT
  } state_t;

  state_t state_r;

  logic [PHASE_W-1:0] phase_sel_r;
  logic [THR_W-1:0]   clip_thr_r;
  logic [THR_W-1:0]   tol_low_r;
  logic [THR_W-1:0]   tol_high_r;

  logic                       out_valid_r;
  logic [RMS_W-1:0]           rms_out_r;
  logic [SAMPLE_W-1:0]        p2p_out_r;
  logic signed [SAMPLE_W-1:0] dc_out_r;
  logic [CLIP_W-1:0]          clip_out_r;
  logic                       tol_out_r;

  acc_ctrl_t                  acc_ctrl;
  logic signed [SAMPLE_W-1:0] sel_sample;
  logic                       in_beat;
  logic                       out_free;
  logic                       win_end;
  logic [CNT_W-1:0]           count;
  logic [SQ_W-1:0]            sq_sum;
  logic signed [SUM_W-1:0]    plain_sum;
  logic signed [SAMPLE_W-1:0] run_max;
  logic signed [SAMPLE_W-1:0] run_min;
  logic [CLIP_W-1:0]          clip_cnt;
  logic                       solv_start_r;
  logic                       solv_done;
  solv_res_t                  solv_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_sel_r <= PHASE_SEL_RST;
      clip_thr_r  <= CLIP_THR_RST;
      tol_low_r   <= TOL_LOW_RST;
      tol_high_r  <= TOL_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PHASE_SELECT:   phase_sel_r <= cfg_data[PHASE_W-1:0];
        CFG_CLIP_THRESHOLD: clip_thr_r  <= cfg_data[THR_W-1:0];
        CFG_TOL_LOW:        tol_low_r   <= cfg_data[THR_W-1:0];
        CFG_TOL_HIGH:       tol_high_r  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // unused phase code falls through to phase C
  always_comb begin
    case (phase_sel_r)
      PHASE_A: sel_sample = in_stream.phase_a;
      PHASE_B: sel_sample = in_stream.phase_b;
      default: sel_sample = in_stream.phase_c;
    endcase
  end

  assign in_stream.ready = (state_r == T_IDLE);
  assign in_beat         = in_stream.valid && in_stream.ready;
  assign out_free        = !out_valid_r || out_stream.ready;

  assign acc_ctrl.load   = in_beat;
  assign acc_ctrl.square = (state_r == T_SQUARE);
  assign acc_ctrl.accum  = (state_r == T_ACCUM);
  assign acc_ctrl.clear  = (state_r == T_EMIT) && out_free;

  wwsc_acc #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .SQ_W        (SQ_W),
    .SUM_W       (SUM_W)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (acc_ctrl),
    .sample    (sel_sample),
    .last      (in_stream.last_sample),
    .clip_thr  (clip_thr_r),
    .win_end   (win_end),
    .count     (count),
    .sq_sum    (sq_sum),
    .plain_sum (plain_sum),
    .run_max   (run_max),
    .run_min   (run_min),
    .clip_cnt  (clip_cnt)
  );

  wwsc_solver #(
    .CNT_W (CNT_W),
    .SQ_W  (SQ_W),
    .SUM_W (SUM_W)
  ) u_solver (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (solv_start_r),
    .sq_sum    (sq_sum),
    .plain_sum (plain_sum),
    .count     (count),
    .done      (solv_done),
    .res       (solv_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      out_valid_r  <= 1'b0;
      solv_start_r <= 1'b0;
    end else begin
      // start the solver once the last sample has landed in the sums
      solv_start_r <= (state_r == T_ACCUM) && win_end;
      out_valid_r  <= acc_ctrl.clear || (out_valid_r && !out_stream.ready);
      unique case (state_r)
        T_IDLE:   if (in_beat) state_r <= T_SQUARE;
        T_SQUARE: state_r <= T_ACCUM;
        T_ACCUM:  state_r <= win_end ? T_SOLVE : T_IDLE;
        T_SOLVE:  if (solv_done) state_r <= T_EMIT;
        T_EMIT: begin
          // hold until the previous result beat has left
          if (out_free) begin
            rms_out_r   <= solv_res.rms;
            p2p_out_r   <= $unsigned(run_max) - $unsigned(run_min);
            dc_out_r    <= solv_res.dc;
            clip_out_r  <= clip_cnt;
            tol_out_r   <= (solv_res.rms >= {1'b0, tol_low_r}) &&
                           (solv_res.rms <= {1'b0, tol_high_r});
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_stream.valid        = out_valid_r;
  assign out_stream.rms_value    = rms_out_r;
  assign out_stream.peak_span    = p2p_out_r;
  assign out_stream.dc_offset    = dc_out_r;
  assign out_stream.clip_count   = clip_out_r;
  assign out_stream.in_tolerance = tol_out_r;

endmodule

[tb/testbench.sv]
module testbench import wwsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_CAP    = 1024;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 150;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 250;
  localparam int PHASE_ITEMS   = 60;

  localparam logic [PHASE_W-1:0] PHASE_C_SEL = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_SPARE = 2'd3;

  typedef struct {
    logic        [RMS_W-1:0]    rms;
    logic        [SAMPLE_W-1:0] p2p;
    logic signed [SAMPLE_W-1:0] dc;
    logic        [CLIP_W-1:0]   clips;
    logic                       in_tol;
  } window_stats_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wwsc_in_if  in_ch ();
  wwsc_out_if out_ch ();

  waveform_window_statistics_core #(.MAX_SAMPLES(WINDOW_CAP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_stream (in_ch),
    .out_stream(out_ch)
  );

  // register shadows
  logic [PHASE_W-1:0] sel_now;
  logic [THR_W-1:0]   thr_now;
  logic [THR_W-1:0]   tol_lo_now;
  logic [THR_W-1:0]   tol_hi_now;

  // window accumulators
  logic [CLIP_W-1:0]          win_count;
  logic [40:0]                sq_sum;
  logic signed [25:0]         lin_sum;
  logic signed [SAMPLE_W-1:0] win_max;
  logic signed [SAMPLE_W-1:0] win_min;
  logic [CLIP_W-1:0]          clip_tally;

  window_stats_t pending_windows[$];
  int            mismatches;
  int            items_sent;
  bit            in_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic longint floor_root(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic clear_window();
    win_count  = '0;
    sq_sum     = '0;
    lin_sum    = '0;
    win_max    = '0;
    win_min    = '0;
    clip_tally = '0;
  endtask

  task automatic account_sample(input logic signed [SAMPLE_W-1:0] pa, pb, pc,
                                input logic last);
    logic signed [SAMPLE_W-1:0] s;
    int                         mag;
    longint                     root;
    window_stats_t              r;
    case (sel_now)
      PHASE_A: s = pa;
      PHASE_B: s = pb;
      default: s = pc;
    endcase
    if (win_count == 0) begin
      win_max = s;
      win_min = s;
    end else begin
      if (s > win_max) win_max = s;
      if (s < win_min) win_min = s;
    end
    mag = (s < 0) ? -int'(s) : int'(s);
    sq_sum  = sq_sum + 41'(longint'(mag) * longint'(mag));
    lin_sum = lin_sum + s;
    if (mag >= int'(thr_now)) clip_tally = clip_tally + 1'b1;
    win_count = win_count + 1'b1;
    if (last || win_count == WINDOW_CAP) begin
      root     = floor_root(longint'(sq_sum) / longint'(win_count));
      r.rms    = RMS_W'(root);
      r.p2p    = SAMPLE_W'(int'(win_max) - int'(win_min));
      r.dc     = SAMPLE_W'(longint'(lin_sum) / longint'(win_count));
      r.clips  = clip_tally;
      r.in_tol = (root >= longint'(tol_lo_now)) && (root <= longint'(tol_hi_now));
      pending_windows.push_back(r);
      clear_window();
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      account_sample(in_ch.phase_a, in_ch.phase_b, in_ch.phase_c, in_ch.last_sample);
  end

  always @(posedge clk) begin
    window_stats_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_windows.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, rms_value %0d peak_span %0d dc_offset %0d",
                 $time, out_ch.rms_value, out_ch.peak_span, out_ch.dc_offset);
      end else begin
        want = pending_windows.pop_front();
        check_field("rms_value", want.rms, out_ch.rms_value);
        check_field("peak_span", want.p2p, out_ch.peak_span);
        check_field("dc_offset", want.dc, out_ch.dc_offset);
        check_field("clip_count", want.clips, out_ch.clip_count);
        check_field("in_tolerance", want.in_tol, out_ch.in_tolerance);
      end
    end
  end

  // result side: ready bursts broken by random stalls
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("waveform_window_statistics_core: mismatch");
    $finish;
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] pa, pb, pc, input logic last);
    int gap;
    gap = in_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.phase_a     <= pa;
    in_ch.phase_b     <= pb;
    in_ch.phase_c     <= pc;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // put the value on the analysed phase, noise on the other two
  task automatic send_on_lane(input logic signed [SAMPLE_W-1:0] v, input logic last);
    case (sel_now)
      PHASE_A: send_sample(v, 16'($urandom), 16'($urandom), last);
      PHASE_B: send_sample(16'($urandom), v, 16'($urandom), last);
      default: send_sample(16'($urandom), 16'($urandom), v, last);
    endcase
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() != 0) @(posedge clk);
    // a sample that ends no window may still be in the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [PHASE_W-1:0] sel, input logic [THR_W-1:0] thr,
                                input logic [THR_W-1:0] lo, input logic [THR_W-1:0] hi);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PHASE_SELECT;
    cfg_data  <= CFG_DATA_W'(sel);
    @(posedge clk);
    sel_now   = sel;
    cfg_index <= CFG_CLIP_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    thr_now   = thr;
    cfg_index <= CFG_TOL_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    tol_lo_now = lo;
    cfg_index <= CFG_TOL_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    tol_hi_now = hi;
    cfg_we    <= 1'b0;
  endtask

  task automatic test_window_extremes();
    send_on_lane(-32768, 1'b1);
    send_on_lane(32767, 1'b1);
    send_on_lane(0, 1'b1);
    send_on_lane(32767, 1'b0);
    send_on_lane(-32768, 1'b1);
    // mean of -3.5 must truncate toward zero
    send_on_lane(-3, 1'b0);
    send_on_lane(-4, 1'b1);
  endtask

  task automatic test_clip_and_tolerance_edges();
    send_on_lane(20793, 1'b0);
    send_on_lane(20794, 1'b0);
    send_on_lane(-20794, 1'b0);
    send_on_lane(-20793, 1'b1);
    send_on_lane(13247, 1'b1);
    send_on_lane(-13248, 1'b1);
    send_on_lane(16192, 1'b1);
    send_on_lane(16193, 1'b1);
  endtask

  task automatic test_phase_lanes();
    logic [PHASE_W-1:0] lanes [4] = '{PHASE_B, PHASE_C_SEL, PHASE_SPARE, PHASE_A};
    foreach (lanes[i]) begin
      apply_settings(lanes[i], CLIP_THR_RST, TOL_LOW_RST, TOL_HIGH_RST);
      send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    end
    // switch phase in the middle of a window
    apply_settings(PHASE_B, CLIP_THR_RST, TOL_LOW_RST, TOL_HIGH_RST);
    send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    apply_settings(PHASE_C_SEL, CLIP_THR_RST, TOL_LOW_RST, TOL_HIGH_RST);
    send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
  endtask

  task automatic test_tolerance_settings();
    // reversed band never matches
    apply_settings(PHASE_A, CLIP_THR_RST, 15'd16000, 15'd14000);
    send_on_lane(15000, 1'b1);
    apply_settings(PHASE_A, CLIP_THR_RST, 15'd0, 15'd32767);
    send_on_lane(0, 1'b1);
    send_on_lane(-32768, 1'b1);
    apply_settings(PHASE_A, CLIP_THR_RST, 15'd0, 15'd0);
    send_on_lane(0, 1'b1);
    apply_settings(PHASE_A, CLIP_THR_RST, 15'd32767, 15'd32767);
    send_on_lane(32767, 1'b1);
  endtask

  task automatic test_threshold_extremes();
    apply_settings(PHASE_C_SEL, 15'd0, TOL_LOW_RST, TOL_HIGH_RST);
    send_on_lane(0, 1'b0);
    send_on_lane(1, 1'b1);
    apply_settings(PHASE_C_SEL, 15'd32767, TOL_LOW_RST, TOL_HIGH_RST);
    send_on_lane(32766, 1'b0);
    send_on_lane(32767, 1'b0);
    send_on_lane(-32768, 1'b1);
  endtask

  task automatic test_window_cap();
    apply_settings(PHASE_B, CLIP_THR_RST, TOL_LOW_RST, TOL_HIGH_RST);
    // full-scale window closed by the sample count alone
    repeat (WINDOW_CAP) send_on_lane(-32768, 1'b0);
    send_on_lane(5, 1'b1);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_level();
    int m;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: m = int'(thr_now) + int'($urandom_range(0, 4)) - 2;
      3: m = int'($urandom_range(0, 200)) - 100;
      4, 5: m = ($urandom_range(0, 1) ? int'(tol_lo_now) : int'(tol_hi_now))
                + int'($urandom_range(0, 4)) - 2;
      default: return 16'($urandom);
    endcase
    if ($urandom_range(0, 1)) m = -m;
    return 16'(m);
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return CLIP_THR_RST;
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic int pick_window_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 8);
    if (r < 88) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  task automatic test_random_windows();
    int               first_item;
    int               phase_start;
    int               len;
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
    first_item  = items_sent;
    phase_start = items_sent - PHASE_ITEMS;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (items_sent - phase_start >= PHASE_ITEMS) begin
        lo = 15'($urandom_range(0, 20000));
        hi = 15'(int'(lo) + int'($urandom_range(0, 12000)));
        if ($urandom_range(0, 4) == 0) apply_settings(2'($urandom), pick_threshold(), hi, lo);
        else apply_settings(2'($urandom), pick_threshold(), lo, hi);
        phase_start = items_sent;
      end
      len = pick_window_len();
      in_burst = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < len; k++) begin
        send_on_lane(pick_level(), k == len - 1);
        // hold the sender now and then until the results have drained
        if ($urandom_range(0, 299) == 0) wait_for_drain();
      end
    end
    in_burst = 1'b0;
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_PHASE_SELECT;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.phase_a     <= '0;
    in_ch.phase_b     <= '0;
    in_ch.phase_c     <= '0;
    in_ch.last_sample <= 1'b0;
    sel_now    = PHASE_SEL_RST;
    thr_now    = CLIP_THR_RST;
    tol_lo_now = TOL_LOW_RST;
    tol_hi_now = TOL_HIGH_RST;
    clear_window();
    mismatches = 0;
    items_sent = 0;
    in_burst   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_window_extremes();
    test_clip_and_tolerance_edges();
    test_phase_lanes();
    test_tolerance_settings();
    test_threshold_extremes();
    test_window_cap();
    test_random_windows();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("waveform_window_statistics_core: match");
    end else begin
      $display("waveform_window_statistics_core: mismatch");
    end
    $finish;
  end

endmodule
